/* sv/maf_pkg.sv */
package maf_pkg;

	// field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int WLEN_W     = 7;
	localparam int WLEN_RESET = 8;

	// apb register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_IDX_WINDOW_LEN = 1'b0;

	// saturation bounds of the mean
	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN_MAG = 32768;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_HOLD
	} div_state_t;

	// configuration seen by front and back
	typedef struct packed {
		logic              clear;
		logic [WLEN_W-1:0] window_len;
	} ctrl_t;

endpackage

/* sv/moving_average_filter.sv */
// Boxcar moving average over the last window_len signed 16-bit samples.
// Input channel: in_valid / in_ready with sample_in; an item is taken when
// both are high. Output channel: out_valid / out_ready with mean_out, the
// sum of the window divided by window_len, truncated toward zero and
// clamped to 16 bits. Samples older than the first one count as zero.
// window_len is set from pwdata[6:0] at APB byte address 0 (1..MAX_WINDOW,
// zero becomes one, larger values become MAX_WINDOW); a write clears the
// history, running sum and ring position. Write it only while idle.
// The front takes a sample, reads the oldest slot of the history ring and
// updates the running sum in F_READ, then queues it in F_PUSH. The back is a
// restoring divider that retires one quotient bit per cycle.
// Sustained throughput is set by the serial divider, which works on one sum
// at a time and takes the next only once its result is loaded; the front
// can take further samples while it runs.
// Reset brings window_len to 8 and empties history, queue and output.
// If the receiver stalls, the result holds in the output register, the
// divider waits, and the front keeps taking items until the two-entry
// queue fills, after which in_ready drops.
module moving_average_filter #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [maf_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [maf_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [maf_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [maf_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [maf_pkg::SAMPLE_W-1:0]   mean_out
);

	localparam int TOT_W = maf_pkg::SAMPLE_W + 1 + $clog2(MAX_WINDOW);
	localparam int WW    = maf_pkg::WLEN_W;
	localparam int LIM_W = ($clog2(MAX_WINDOW + 1) > WW) ? $clog2(MAX_WINDOW + 1) : WW;
	localparam int WLEN_RST = (maf_pkg::WLEN_RESET < MAX_WINDOW) ? maf_pkg::WLEN_RESET
		: MAX_WINDOW;

	logic [WW-1:0]           window_len_q;
	logic [WW-1:0]           wlen_raw;
	logic [WW-1:0]           wlen_new;
	logic                    wr_window;
	maf_pkg::ctrl_t          ctrl;
	logic                    push_valid, push_ready;
	logic signed [TOT_W-1:0] push_total;
	logic                    pop_valid, pop_ready;
	logic [TOT_W-1:0]        pop_data;

	// apb register access
	assign pready    = 1'b1;
	assign wr_window = psel & penable & pwrite & pready
		& (paddr[maf_pkg::APB_ADDR_W-1:2] == maf_pkg::REG_IDX_WINDOW_LEN);
	assign prdata    = maf_pkg::APB_DATA_W'(window_len_q);

	// clamp the written window length into range
	assign wlen_raw = pwdata[WW-1:0];
	always_comb begin
		if (wlen_raw == '0) begin
			wlen_new = WW'(1);
		end else if (LIM_W'(wlen_raw) > LIM_W'(MAX_WINDOW)) begin
			wlen_new = WW'(MAX_WINDOW);
		end else begin
			wlen_new = wlen_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WW'(WLEN_RST);
		end else if (wr_window) begin
			window_len_q <= wlen_new;
		end
	end

	assign ctrl.clear      = wr_window;
	assign ctrl.window_len = window_len_q;

	// front: history ring and running sum
	maf_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.TOT_W     (TOT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_total(push_total)
	);

	// queue of sums between front and divider
	maf_fifo #(
		.WIDTH(TOT_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_total),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// back: serial divide and clamp
	maf_div #(
		.TOT_W(TOT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_total($signed(pop_data)),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_out (mean_out)
	);

endmodule

/* sv/maf_ram.sv */
module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/maf_front.sv */
module maf_front #(
	parameter int MAX_WINDOW = 64,
	parameter int TOT_W      = 23
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  maf_pkg::ctrl_t                      ctrl,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [maf_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic signed [TOT_W-1:0]             push_total
);

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W = (AW + 1 > maf_pkg::WLEN_W) ? AW + 1 : maf_pkg::WLEN_W;

	maf_pkg::front_state_t state_q, state_d;

	logic [AW-1:0]                        pos_q;
	logic                                 wrapped_q;
	logic signed [TOT_W-1:0]              total_q;
	logic signed [maf_pkg::SAMPLE_W-1:0]  sample_q;
	logic                                 accept;
	logic                                 ram_we;
	logic [maf_pkg::SAMPLE_W-1:0]         ram_rdata;
	logic signed [maf_pkg::SAMPLE_W-1:0]  old_sample;
	logic signed [TOT_W-1:0]              new_total;
	logic [CMP_W-1:0]                     pos_inc;
	logic                                 wrap;

	// history ring
	maf_ram #(
		.WIDTH(maf_pkg::SAMPLE_W),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(sample_q),
		.re   (accept),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			maf_pkg::F_IDLE: begin
				if (in_valid) state_d = maf_pkg::F_READ;
			end
			maf_pkg::F_READ: begin
				state_d = maf_pkg::F_PUSH;
			end
			maf_pkg::F_PUSH: begin
				if (push_ready) state_d = maf_pkg::F_IDLE;
			end
			default: begin
				state_d = maf_pkg::F_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready   = 1'b0;
		push_valid = 1'b0;
		ram_we     = 1'b0;
		case (state_q)
			maf_pkg::F_IDLE: in_ready   = 1'b1;
			maf_pkg::F_READ: ram_we     = 1'b1;
			maf_pkg::F_PUSH: push_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid & in_ready;

	// slot not yet written since the last clear reads as zero
	assign old_sample = wrapped_q ? $signed(ram_rdata) : '0;
	assign new_total  = total_q + TOT_W'(sample_q) - TOT_W'(old_sample);
	assign pos_inc    = CMP_W'(pos_q) + CMP_W'(1);
	assign wrap       = pos_inc >= CMP_W'(ctrl.window_len);
	assign push_total = total_q;

	// sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
		end
	end

	// control and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= maf_pkg::F_IDLE;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			total_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.clear) begin
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				total_q   <= '0;
			end else if (state_q == maf_pkg::F_READ) begin
				total_q <= new_total;
				if (wrap) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[AW-1:0];
				end
			end
		end
	end

	// ring position stays inside the window
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(pos_q) < CMP_W'(ctrl.window_len))
		else $error("ring position outside window");

endmodule

/* sv/maf_fifo.sv */
module maf_fifo #(
	parameter int WIDTH = 23
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (maf_pkg::QDEPTH > 1) ? $clog2(maf_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(maf_pkg::QDEPTH + 1);

	logic [WIDTH-1:0] entry_q [maf_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q < CNT_W'(maf_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(maf_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(maf_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// fill level never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(maf_pkg::QDEPTH))
		else $error("queue overflow");

endmodule

/* sv/maf_div.sv */
module maf_div #(
	parameter int TOT_W = 23
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  maf_pkg::ctrl_t                      ctrl,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  logic signed [TOT_W-1:0]             pop_total,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [maf_pkg::SAMPLE_W-1:0] mean_out
);

	localparam int CNT_W = $clog2(TOT_W + 1);
	localparam int WW    = maf_pkg::WLEN_W;

	maf_pkg::div_state_t state_q, state_d;

	logic [CNT_W-1:0]                    cnt_q;
	logic [TOT_W-1:0]                    quo_q;
	logic [WW-1:0]                       rem_q;
	logic                                neg_q;
	logic                                out_valid_q;
	logic signed [maf_pkg::SAMPLE_W-1:0] mean_q;
	logic                                load_out;
	logic [WW:0]                         rem_sh;
	logic [WW+1:0]                       diff;
	logic                                ge;
	logic signed [maf_pkg::SAMPLE_W-1:0] sat_mean;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			maf_pkg::D_IDLE: begin
				if (pop_valid) state_d = maf_pkg::D_RUN;
			end
			maf_pkg::D_RUN: begin
				if (cnt_q == CNT_W'(TOT_W - 1)) state_d = maf_pkg::D_HOLD;
			end
			maf_pkg::D_HOLD: begin
				if (!out_valid_q || out_ready) state_d = maf_pkg::D_IDLE;
			end
			default: begin
				state_d = maf_pkg::D_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			maf_pkg::D_IDLE: pop_ready = 1'b1;
			maf_pkg::D_HOLD: load_out  = !out_valid_q || out_ready;
			default: begin
				pop_ready = 1'b0;
			end
		endcase
	end

	// one restoring step per cycle
	assign rem_sh = {rem_q, quo_q[TOT_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, ctrl.window_len};
	assign ge     = !diff[WW+1];

	// sign and clamp the quotient
	always_comb begin
		if (neg_q) begin
			if (quo_q > TOT_W'(maf_pkg::SAT_MIN_MAG)) begin
				sat_mean = {1'b1, {(maf_pkg::SAMPLE_W-1){1'b0}}};
			end else begin
				sat_mean = -$signed(quo_q[maf_pkg::SAMPLE_W-1:0]);
			end
		end else begin
			if (quo_q > TOT_W'(maf_pkg::SAT_MAX)) begin
				sat_mean = {1'b0, {(maf_pkg::SAMPLE_W-1){1'b1}}};
			end else begin
				sat_mean = $signed(quo_q[maf_pkg::SAMPLE_W-1:0]);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			quo_q <= pop_total[TOT_W-1] ? TOT_W'(-pop_total) : TOT_W'(pop_total);
			neg_q <= pop_total[TOT_W-1];
			rem_q <= '0;
		end else if (state_q == maf_pkg::D_RUN) begin
			quo_q <= {quo_q[TOT_W-2:0], ge};
			rem_q <= ge ? diff[WW-1:0] : rem_sh[WW-1:0];
		end
		if (load_out) begin
			mean_q <= sat_mean;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= maf_pkg::D_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == maf_pkg::D_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == maf_pkg::D_RUN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign mean_out  = mean_q;

	// a finished quotient has gone through every step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == maf_pkg::D_HOLD) |-> (cnt_q == CNT_W'(TOT_W)))
		else $error("divider left early");

	// the result register is only loaded when free or being drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load_out)
		else $error("result overwritten");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int MAX_WINDOW = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_IDLE = 17;
	// byte addresses of the register map
	localparam logic [maf_pkg::APB_ADDR_W-1:0] ADDR_WINDOW_LEN =
		maf_pkg::APB_ADDR_W'(4 * maf_pkg::REG_IDX_WINDOW_LEN);
	localparam logic [maf_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = maf_pkg::APB_ADDR_W'(4);

	typedef logic signed [maf_pkg::SAMPLE_W-1:0] sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [maf_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [maf_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [maf_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	sample_t sample_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sample_t mean_out;

	// predictor state
	sample_t hist_ring [MAX_WINDOW];
	int ring_sum;
	int ring_slot;
	int win_len;

	sample_t mean_queue [$];
	int error_count = 0;
	int cycle_count = 0;
	int out_stall = 0;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;

	moving_average_filter #(
		.MAX_WINDOW(MAX_WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_out(mean_out)
	);

	always #4 clk = ~clk;

	// clear the ring, sum and slot
	function automatic void clear_ring();
		foreach (hist_ring[i]) hist_ring[i] = '0;
		ring_sum = 0;
		ring_slot = 0;
	endfunction

	// window length as the block takes it, clamped to 1..MAX_WINDOW
	function automatic void apply_window_len(input logic [maf_pkg::APB_DATA_W-1:0] data);
		int len;
		len = int'(data[maf_pkg::WLEN_W-1:0]);
		if (len < 1) len = 1;
		if (len > MAX_WINDOW) len = MAX_WINDOW;
		win_len = len;
		clear_ring();
	endfunction

	// push one sample into the ring and return the truncated, clamped mean
	function automatic sample_t boxcar_mean(input sample_t s);
		int q;
		if (ring_slot >= win_len) ring_slot = 0;
		ring_sum = ring_sum + int'(s) - int'(hist_ring[ring_slot]);
		hist_ring[ring_slot] = s;
		ring_slot++;
		if (ring_slot >= win_len) ring_slot = 0;
		q = ring_sum / win_len;
		if (q > maf_pkg::SAT_MAX) q = maf_pkg::SAT_MAX;
		else if (q < -maf_pkg::SAT_MIN_MAG) q = -maf_pkg::SAT_MIN_MAG;
		return sample_t'(q);
	endfunction

	// mostly full-range values, some extremes and some near zero
	function automatic sample_t draw_sample();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) return sample_t'(-maf_pkg::SAT_MIN_MAG);
		if (pick < 4) return sample_t'(maf_pkg::SAT_MAX);
		if (pick < 7) return sample_t'($signed($urandom_range(0, 64)) - 32);
		return sample_t'($urandom);
	endfunction

	// send one item, keeping valid high across back-to-back items
	task automatic send_sample(input sample_t s);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
		mean_queue.insert(mean_queue.size(), boxcar_mean(s));
	endtask

	// drop valid and wait until every expected mean is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mean_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle
	task automatic apb_write(input logic [maf_pkg::APB_ADDR_W-1:0] addr,
		input logic [maf_pkg::APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW_LEN) apply_window_len(data);
	endtask

	// default window after reset, extremes and truncation of negative means
	task automatic test_reset_window();
		repeat (4) send_sample(sample_t'(maf_pkg::SAT_MAX));
		repeat (4) send_sample(sample_t'(-maf_pkg::SAT_MIN_MAG));
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(-16'sd7);
		send_sample(16'sd5);
		wait_drained();
	endtask

	// window of one, clamping of zero and oversize writes, unmapped address
	task automatic test_window_extremes();
		apb_write(ADDR_WINDOW_LEN, 32'd1);
		send_sample(sample_t'(-maf_pkg::SAT_MIN_MAG));
		send_sample(sample_t'(maf_pkg::SAT_MAX));
		send_sample(-16'sd3);
		wait_drained();
		apb_write(ADDR_WINDOW_LEN, 32'd127);
		repeat (3) send_sample(sample_t'(-maf_pkg::SAT_MIN_MAG));
		wait_drained();
		apb_write(ADDR_WINDOW_LEN, 32'd0);
		send_sample(16'sd7);
		wait_drained();
		// write to an unmapped register leaves window and history alone
		apb_write(ADDR_UNMAPPED, 32'd9);
		send_sample(-16'sd5);
		wait_drained();
	endtask

	// random phases over several window settings
	task automatic test_random_windows();
		logic [maf_pkg::APB_DATA_W-1:0] settings [5];
		settings[0] = 32'd64;
		settings[1] = 32'd2;
		settings[2] = $urandom_range(3, 63);
		settings[3] = 32'hFFFF_FF80 | ($urandom & 32'h0000_007E) | 32'd3;
		settings[4] = 32'd1;
		foreach (settings[p]) begin
			apb_write(ADDR_WINDOW_LEN, settings[p]);
			for (int n = 0; n < 90; n++) begin
				if (n % 30 == 0) begin
					in_burst = ($urandom_range(0, 3) == 0);
					out_burst = ($urandom_range(0, 3) == 0);
				end
				// sender holds off once until all means are out
				if (p == 2 && n == 45) wait_drained();
				send_sample(draw_sample());
			end
			wait_drained();
		end
		in_burst = 1'b0;
		out_burst = 1'b0;
	endtask

	// result check, receiver stalls and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[moving_average_filter] ERROR");
			$finish;
		end else begin
			if (out_valid && out_ready) begin
				if (mean_queue.size() == 0) begin
					$display("%0t mean_out unexpected item: expected none, got %0d",
						$time, mean_out);
					error_count++;
				end else if (mean_out !== mean_queue[0]) begin
					$display("%0t mean_out mismatch: expected %0d, got %0d",
						$time, mean_queue[0], mean_out);
					error_count++;
					void'(mean_queue.pop_front());
				end else begin
					void'(mean_queue.pop_front());
				end
				out_stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
				out_ready <= (out_stall == 0);
			end else begin
				if (out_stall > 0) out_stall--;
				out_ready <= (out_stall == 0);
			end
		end
	end

	initial begin
		win_len = (maf_pkg::WLEN_RESET < MAX_WINDOW) ? maf_pkg::WLEN_RESET : MAX_WINDOW;
		clear_ring();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_window_extremes();
		test_random_windows();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("[moving_average_filter] OK");
		end else begin
			$display("[moving_average_filter] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/maf_pkg.sv
sv/maf_ram.sv
sv/maf_front.sv
sv/maf_fifo.sv
sv/maf_div.sv
sv/moving_average_filter.sv
verif/tb.sv
